[design/lru_key_value_cache_assert.svh]
// Assertion macros used by the cache datapath.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LKV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cache assertion failed");

// Next-cycle implication, checked outside reset.
`define LKV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cache assertion failed");

`endif

[design/lkv_pkg.sv]
// Shared constants and control types for the LRU key-value cache.
package lkv_pkg;

    localparam int ENTRIES_DEFAULT    = 16;
    localparam int KEY_BITS_DEFAULT   = 32;
    localparam int VALUE_BITS_DEFAULT = 32;

    // Capacity register.
    localparam int             CAP_BITS  = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // Request type codes.
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic req_ready;
        logic load_req;
        logic lookup;
        logic update;
    } lkv_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } lkv_status_t;

endpackage

[design/lkv_if.sv]
// Request and response channel interfaces for the LRU key-value cache.
interface lkv_req_if #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output req_type, output key, output value, input ready);
    modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

interface lkv_rsp_if #(
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

[design/lkv_ctrl.sv]
// Controller state machine: accept, lookup and update phases of a request.
module lkv_ctrl
    import lkv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  lkv_status_t st,
    output lkv_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next    = state_reg;
        cmd.req_ready = 1'b0;
        cmd.load_req  = 1'b0;
        cmd.lookup    = 1'b0;
        cmd.update    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.req_ready = 1'b1;
                cmd.load_req  = in_valid;
                if (in_valid)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                cmd.lookup = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                // Hold here until the output register can take the result.
                if (st.out_free)
                begin
                    cmd.update = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[design/lkv_datapath.sv]
// Datapath: entry store, parallel key match, recency ranks and result register.
module lkv_datapath
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEFAULT,
    parameter int KEY_BITS   = KEY_BITS_DEFAULT,
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CAP_BITS-1:0]   cfg_write_data,
    input  logic                  req_type,
    input  logic [KEY_BITS-1:0]   req_key,
    input  logic [VALUE_BITS-1:0] req_value,
    input  logic                  rsp_ready,
    input  lkv_cmd_t              cmd,
    output lkv_status_t           st,
    output logic                  rsp_valid,
    output logic                  rsp_hit,
    output logic [VALUE_BITS-1:0] rsp_read_value
);

`include "lru_key_value_cache_assert.svh"

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

    // Configuration and request registers.
    logic [CAP_BITS-1:0]   capacity_reg;
    logic                  req_type_reg;
    logic [KEY_BITS-1:0]   req_key_reg;
    logic [VALUE_BITS-1:0] req_value_reg;

    // Entry store.
    logic [ENTRIES-1:0]    valid_reg;
    logic [KEY_BITS-1:0]   key_reg   [ENTRIES];
    logic [IDX_W-1:0]      rank_reg  [ENTRIES];
    logic [VALUE_BITS-1:0] value_mem [ENTRIES];
    logic [CNT_W-1:0]      count_reg;

    // Lookup results.
    logic                  hit_reg;
    logic                  fill_reg;
    logic [IDX_W-1:0]      target_reg;
    logic [IDX_W-1:0]      old_rank_reg;

    // Result register.
    logic                  out_valid_reg;
    logic                  out_hit_reg;
    logic                  out_gethit_reg;
    logic [VALUE_BITS-1:0] rd_data_reg;

    // Lookup logic.
    logic [ENTRIES-1:0]    match_vec;
    logic                  hit_any;
    logic [IDX_W-1:0]      found_idx;
    logic [IDX_W-1:0]      free_idx;
    logic [IDX_W-1:0]      oldest_idx;
    logic [IDX_W-1:0]      oldest_rank;
    logic [IDX_W-1:0]      hit_rank;
    logic [CMP_W-1:0]      cap_ext;
    logic [CMP_W-1:0]      cap_eff;
    logic                  fill_ok;
    logic                  is_put;
    logic                  put_miss;

    assign is_put   = (req_type_reg == REQ_PUT);
    assign put_miss = is_put && !hit_reg;

    // Effective capacity: zero acts as one, values above the entry count saturate.
    always_comb
    begin
        cap_ext = CMP_W'(capacity_reg);
        if (cap_ext == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            cap_eff = CMP_W'(ENTRIES);
        end
        else
        begin
            cap_eff = cap_ext;
        end
    end

    // The least recent valid entry always holds rank count-1.
    assign oldest_rank = IDX_W'(count_reg - CNT_W'(1));
    assign fill_ok     = (CMP_W'(count_reg) < cap_eff);

    // Parallel compare against every entry, then priority selection.
    always_comb
    begin
        found_idx  = '0;
        free_idx   = '0;
        oldest_idx = '0;
        hit_rank   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            match_vec[i] = valid_reg[i] && (key_reg[i] == req_key_reg);
            if (match_vec[i])
            begin
                found_idx = IDX_W'(i);
                hit_rank  = hit_rank | rank_reg[i];
            end
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
            if (valid_reg[i] && (rank_reg[i] == oldest_rank))
            begin
                oldest_idx = IDX_W'(i);
            end
        end
        hit_any = |match_vec;
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_write_en)
        begin
            capacity_reg <= cfg_write_data;
        end
    end

    // Request capture and lookup results.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_type_reg  <= req_type;
            req_key_reg   <= req_key;
            req_value_reg <= req_value;
        end
        if (cmd.lookup)
        begin
            hit_reg      <= hit_any;
            fill_reg     <= !hit_any && fill_ok;
            target_reg   <= hit_any ? found_idx : (fill_ok ? free_idx : oldest_idx);
            old_rank_reg <= hit_any ? hit_rank : oldest_rank;
        end
    end

    // Valid bits, ranks and entry count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else if (cmd.update && (hit_reg || is_put))
        begin
            if (put_miss && fill_reg)
            begin
                valid_reg[target_reg] <= 1'b1;
                count_reg             <= count_reg + CNT_W'(1);
            end
            // Touch: the target becomes most recent; newer valid entries age by one, or all valid entries on a fill.
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (IDX_W'(i) == target_reg)
                begin
                    rank_reg[i] <= '0;
                end
                else if (valid_reg[i] && ((put_miss && fill_reg) ||
                                          (rank_reg[i] < old_rank_reg)))
                begin
                    rank_reg[i] <= rank_reg[i] + IDX_W'(1);
                end
            end
        end
    end

    // Keys are written on every put that misses.
    always_ff @(posedge clk)
    begin
        if (cmd.update && put_miss)
        begin
            key_reg[target_reg] <= req_key_reg;
        end
    end

    // Value memory with registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            if (is_put)
            begin
                value_mem[target_reg] <= req_value_reg;
            end
            rd_data_reg    <= value_mem[target_reg];
            out_hit_reg    <= hit_reg;
            out_gethit_reg <= hit_reg && !is_put;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign st.out_free     = !out_valid_reg || rsp_ready;
    assign rsp_valid       = out_valid_reg;
    assign rsp_hit         = out_hit_reg;
    assign rsp_read_value  = out_gethit_reg ? rd_data_reg : '0;

    // The entry count tracks the number of valid entries.
    `LKV_ASSERT_NOW(a_count_matches_valid, clk, rst_n, 1'b1,
        $countones(valid_reg) == int'(count_reg))
    // Keys are unique, so a lookup matches at most one entry.
    `LKV_ASSERT_NOW(a_single_match, clk, rst_n, cmd.lookup, $onehot0(match_vec))
    // A fill adds exactly one entry.
    `LKV_ASSERT_NEXT(a_fill_counts, clk, rst_n, cmd.update && put_miss && fill_reg,
        count_reg == $past(count_reg) + CNT_W'(1))
    // The result register is never overwritten while it holds an untaken word.
    `LKV_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.update && out_valid_reg, rsp_ready)

endmodule

[design/lru_key_value_cache.sv]
// Top level of the fully associative LRU key-value cache.
// Each request word (get or put) passes through three phases in order: the
// accept phase, a lookup phase that compares the key against all entries in parallel and
// registers the chosen slot, and an update phase that writes the entry, rewrites the recency
// ranks and does the registered read of the value memory. The next word is accepted in the
// cycle after the update. Results wait in an output register, so a new word is accepted
// while an earlier result is still pending; a word whose lookup is done waits in its update
// phase until that register frees. Valid bits and ranks are cleared by reset directly, so
// there is no clearing pass. The capacity register may only be written while the cache is
// idle.
module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEFAULT,
    parameter int KEY_BITS   = KEY_BITS_DEFAULT,
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [CAP_BITS-1:0] cfg_write_data,
    lkv_req_if.sink             req,
    lkv_rsp_if.source           rsp
);

    lkv_cmd_t    cmd;
    lkv_status_t st;

    // Request sequencing.
    lkv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .st       (st),
        .cmd      (cmd)
    );

    assign req.ready = cmd.req_ready;

    // Entry store and result register.
    lkv_datapath #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .req_type       (req.req_type),
        .req_key        (req.key),
        .req_value      (req.value),
        .rsp_ready      (rsp.ready),
        .cmd            (cmd),
        .st             (st),
        .rsp_valid      (rsp.valid),
        .rsp_hit        (rsp.hit),
        .rsp_read_value (rsp.read_value)
    );

endmodule
